FILE: design/icmpchk_pkg.sv
// icmpchk_pkg: shared types, constants and the folded checksum add
// for the icmp echo request checker; no dependencies
package icmpchk_pkg;

    // width of the length field carried to the result stage
    localparam int LEN_W = 16;

    // default width of the saturating byte counter
    localparam int DEF_LENGTH_BITS = 16;

    // header layout, byte positions in wire order
    localparam logic [LEN_W-1:0] HDR_BYTES   = 16'd8;
    localparam logic [LEN_W-1:0] POS_TYPE    = 16'd0;
    localparam logic [LEN_W-1:0] POS_CODE    = 16'd1;
    localparam logic [LEN_W-1:0] POS_ID_HI   = 16'd4;
    localparam logic [LEN_W-1:0] POS_ID_LO   = 16'd5;
    localparam logic [LEN_W-1:0] POS_SEQ_HI  = 16'd6;
    localparam logic [LEN_W-1:0] POS_SEQ_LO  = 16'd7;

    // expected header values and checksum target
    localparam logic [7:0]  ECHO_REQUEST_TYPE = 8'd8;
    localparam logic [7:0]  ECHO_CODE         = 8'd0;
    localparam logic [15:0] SUM_ALL_ONES      = 16'hFFFF;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_BAD_TYPE = 2'd2,
        STATUS_BAD_SUM  = 2'd3
    } status_t;

    // message state as it stands after the final byte
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       type_byte;
        logic [7:0]       code_byte;
        logic [15:0]      ident;
        logic [15:0]      seq;
        logic [15:0]      full_sum;
        logic [15:0]      rest_sum;
    } msg_summary_t;

    // one's-complement add with end-around carry
    function automatic logic [15:0] fold_add(input logic [15:0] acc,
                                             input logic [15:0] word);
        logic [16:0] s;
        logic [16:0] r;
        s = {1'b0, acc} + {1'b0, word};
        r = {1'b0, s[15:0]} + {16'd0, s[16]};
        return r[15:0];
    endfunction

endpackage

FILE: design/icmpchk_in_stage.sv
// icmpchk_in_stage: input register for one message byte
// depends on icmpchk_pkg
module icmpchk_in_stage
    import icmpchk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_data,
    output logic       held_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       take;

    // free when empty or when the held byte moves on this cycle
    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;
    assign held_last  = last_reg;

endmodule

FILE: design/icmpchk_accum.sv
// icmpchk_accum: per-message state, header capture and running checksums
// depends on icmpchk_pkg
module icmpchk_accum
    import icmpchk_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data,
    input  logic         last,
    output msg_summary_t summary
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [15:0] full_sum_reg, full_sum_next;
    logic [15:0] rest_sum_reg, rest_sum_next;
    logic [7:0]  high_reg, high_next;
    logic        odd_reg, odd_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] seq_reg, seq_next;
    logic [LEN_W-1:0] pos;
    logic [15:0] word_pair;
    logic [15:0] word_pad;

    assign pos       = LEN_W'(count_reg);
    assign word_pair = {high_reg, data};
    assign word_pad  = {data, 8'h00};

    // saturating byte count
    assign count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

    // header field capture
    always_comb
    begin
        type_next  = (pos == POS_TYPE) ? data : type_reg;
        code_next  = (pos == POS_CODE) ? data : code_reg;
        ident_next = ident_reg;
        seq_next   = seq_reg;
        if (pos == POS_ID_HI)
        begin
            ident_next = {data, ident_reg[7:0]};
        end
        if (pos == POS_ID_LO)
        begin
            ident_next = {ident_reg[15:8], data};
        end
        if (pos == POS_SEQ_HI)
        begin
            seq_next = {data, seq_reg[7:0]};
        end
        if (pos == POS_SEQ_LO)
        begin
            seq_next = {seq_reg[15:8], data};
        end
    end

    // byte pairing and checksum accumulation, odd tail padded with zero
    always_comb
    begin
        full_sum_next = full_sum_reg;
        rest_sum_next = rest_sum_reg;
        high_next     = high_reg;
        odd_next      = odd_reg;
        if (odd_reg)
        begin
            full_sum_next = fold_add(full_sum_reg, word_pair);
            if (pos >= POS_ID_LO)
            begin
                rest_sum_next = fold_add(rest_sum_reg, word_pair);
            end
            odd_next = 1'b0;
        end
        else
        begin
            high_next = data;
            odd_next  = 1'b1;
            if (last)
            begin
                full_sum_next = fold_add(full_sum_reg, word_pad);
                if (pos >= POS_ID_HI)
                begin
                    rest_sum_next = fold_add(rest_sum_reg, word_pad);
                end
            end
        end
    end

    // state after this byte, used by the result stage on the final byte
    always_comb
    begin
        summary.len       = LEN_W'(count_next);
        summary.type_byte = type_next;
        summary.code_byte = code_next;
        summary.ident     = ident_next;
        summary.seq       = seq_next;
        summary.full_sum  = full_sum_next;
        summary.rest_sum  = rest_sum_next;
    end

    // message state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            full_sum_reg <= '0;
            rest_sum_reg <= '0;
            high_reg     <= '0;
            odd_reg      <= 1'b0;
            type_reg     <= '0;
            code_reg     <= '0;
            ident_reg    <= '0;
            seq_reg      <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                count_reg    <= '0;
                full_sum_reg <= '0;
                rest_sum_reg <= '0;
                high_reg     <= '0;
                odd_reg      <= 1'b0;
                type_reg     <= '0;
                code_reg     <= '0;
                ident_reg    <= '0;
                seq_reg      <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                full_sum_reg <= full_sum_next;
                rest_sum_reg <= rest_sum_next;
                high_reg     <= high_next;
                odd_reg      <= odd_next;
                type_reg     <= type_next;
                code_reg     <= code_next;
                ident_reg    <= ident_next;
                seq_reg      <= seq_next;
            end
        end
    end

endmodule

FILE: design/icmpchk_result.sv
// icmpchk_result: status decision and result register
// depends on icmpchk_pkg
module icmpchk_result
    import icmpchk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  msg_summary_t summary,
    output logic         slot_free,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   status,
    output logic [15:0]  identifier,
    output logic [15:0]  sequence_res,
    output logic [15:0]  payload_length,
    output logic [15:0]  reply_checksum
);

    logic        valid_reg, valid_next;
    status_t     status_reg, status_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] csum_reg, csum_next;

    assign slot_free = !valid_reg || out_ready;

    // status with short first, then header, then checksum
    always_comb
    begin
        priority if (summary.len < HDR_BYTES)
        begin
            status_next = STATUS_SHORT;
        end
        else if (summary.type_byte != ECHO_REQUEST_TYPE || summary.code_byte != ECHO_CODE)
        begin
            status_next = STATUS_BAD_TYPE;
        end
        else if (summary.full_sum != SUM_ALL_ONES)
        begin
            status_next = STATUS_BAD_SUM;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    // fields reported only for a good request
    always_comb
    begin
        if (status_next == STATUS_OK)
        begin
            ident_next = summary.ident;
            seq_next   = summary.seq;
            plen_next  = 16'(summary.len - HDR_BYTES);
            csum_next  = ~summary.rest_sum;
        end
        else
        begin
            ident_next = '0;
            seq_next   = '0;
            plen_next  = '0;
            csum_next  = '0;
        end
    end

    always_comb
    begin
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            ident_reg  <= ident_next;
            seq_reg    <= seq_next;
            plen_reg   <= plen_next;
            csum_reg   <= csum_next;
        end
    end

    assign out_valid      = valid_reg;
    assign status         = status_reg;
    assign identifier     = ident_reg;
    assign sequence_res   = seq_reg;
    assign payload_length = plen_reg;
    assign reply_checksum = csum_reg;

endmodule

FILE: design/icmp_echo_request_checker.sv
// icmp_echo_request_checker: checks an icmp echo request byte stream
// a final byte is held in the input register, then its verdict and out_valid are registered in the result stage
// throughput: one byte per cycle but for a blocked final byte; one folded 16-bit checksum add per byte
// a result waiting in the output register stops only the final byte of the next message, not the bytes before it
// reset: rst_n asynchronous, clears message state, input and output valid flags
// depends on icmpchk_pkg, icmpchk_in_stage, icmpchk_accum, icmpchk_result
module icmp_echo_request_checker
    import icmpchk_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] identifier,
    output logic [15:0] sequence_res,
    output logic [15:0] payload_length,
    output logic [15:0] reply_checksum
);

    localparam logic [15:0] MAX_PAYLOAD = 16'((1 << LENGTH_BITS) - 1 - 8);

    logic         held_valid;
    logic [7:0]   held_data;
    logic         held_last;
    logic         advance;
    logic         slot_free;
    logic         fire;
    msg_summary_t summary;

    // a byte moves on unless it is final and the result slot is taken
    assign advance = held_valid && (!held_last || slot_free);
    assign fire    = advance && held_last;

    icmpchk_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data),
        .held_last  (held_last)
    );

    icmpchk_accum #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .data    (held_data),
        .last    (held_last),
        .summary (summary)
    );

    icmpchk_result u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .summary        (summary),
        .slot_free      (slot_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .identifier     (identifier),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .reply_checksum (reply_checksum)
    );

    // a final byte always produces a result next cycle
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("final byte did not produce a result");

    // failing results carry zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |->
        (identifier == 16'd0 && sequence_res == 16'd0 &&
         payload_length == 16'd0 && reply_checksum == 16'd0))
        else $error("failing result has nonzero fields");

    // payload length bounded by the saturating count
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_OK) |-> payload_length <= MAX_PAYLOAD)
        else $error("payload length beyond counter range");

    // back pressure only when a byte is held and blocked
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (held_valid && held_last && !slot_free))
        else $error("input stalled without a blocked final byte");

endmodule

FILE: verif/tb.sv
// tb: self-checking testbench for icmp_echo_request_checker
// drives icmp messages byte by byte and checks each verdict against a local predictor
// depends on icmpchk_pkg and the icmp_echo_request_checker rtl
module tb
    import icmpchk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LEN_BITS    = DEF_LENGTH_BITS;
    localparam int unsigned COUNT_MAX   = (1 << LEN_BITS) - 1;
    localparam int          IDLE_PCT    = 19;
    localparam int          CYCLE_LIMIT = 500000;

    // one verdict as the block reports it
    typedef struct packed {
        status_t     st;
        logic [15:0] ident;
        logic [15:0] seq;
        logic [15:0] plen;
        logic [15:0] rcsum;
    } echo_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [15:0] identifier;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [15:0] reply_checksum;

    // message under construction and verdicts still owed by the block
    logic [7:0]    pkt[$];
    echo_verdict_t pending_verdicts[$];

    // predictor copy of the message state
    int unsigned rx_count;
    logic [15:0] sum_all;
    logic [15:0] sum_tail;
    logic [7:0]  pend_hi;
    logic        pend_odd;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_code;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;

    // run bookkeeping
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned bytes_sent;
    int unsigned msgs_sent;
    int unsigned verdicts_checked;
    int unsigned status_hits[4];
    bit          quiet_mode;

    // receiver hold-off requests
    int unsigned hold_ask_len;
    int unsigned hold_ask_id;
    int unsigned hold_done_id;
    int unsigned hold_left;

    icmp_echo_request_checker #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .identifier(identifier),
        .sequence_res(sequence_res),
        .payload_length(payload_length),
        .reply_checksum(reply_checksum)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("icmp_echo_request_checker: mismatch");
            $finish;
        end
    end

    // one's-complement 16-bit add with end-around carry
    function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] t;
        t = {1'b0, acc} + {1'b0, word};
        t = {1'b0, t[15:0]} + {16'd0, t[16]};
        return t[15:0];
    endfunction

    function automatic void clear_msg_state();
        rx_count = 0;
        sum_all  = 16'h0000;
        sum_tail = 16'h0000;
        pend_hi  = 8'h00;
        pend_odd = 1'b0;
        hdr_type = 8'h00;
        hdr_code = 8'h00;
        echo_id  = 16'h0000;
        echo_seq = 16'h0000;
    endfunction

    // advance the predictor by one accepted byte, queue a verdict on the last one
    function automatic void predict_echo_byte(input logic [7:0] b, input logic fin);
        int unsigned   pos;
        echo_verdict_t v;
        pos = rx_count;
        bytes_sent++;

        // header capture
        if (pos == POS_TYPE)   hdr_type = b;
        if (pos == POS_CODE)   hdr_code = b;
        if (pos == POS_ID_HI)  echo_id[15:8] = b;
        if (pos == POS_ID_LO)  echo_id[7:0] = b;
        if (pos == POS_SEQ_HI) echo_seq[15:8] = b;
        if (pos == POS_SEQ_LO) echo_seq[7:0] = b;

        // big-endian pairing, kept apart from the saturating count
        if (pend_odd)
        begin
            sum_all = csum_add(sum_all, {pend_hi, b});
            if (pos >= POS_ID_LO)
                sum_tail = csum_add(sum_tail, {pend_hi, b});
            pend_odd = 1'b0;
        end
        else
        begin
            pend_hi  = b;
            pend_odd = 1'b1;
        end

        if (rx_count < COUNT_MAX)
            rx_count++;

        if (!fin)
            return;

        // odd final byte padded with a zero low byte
        if (pend_odd)
        begin
            sum_all = csum_add(sum_all, {pend_hi, 8'h00});
            if (pos >= POS_ID_HI)
                sum_tail = csum_add(sum_tail, {pend_hi, 8'h00});
        end

        v = '0;
        if (rx_count < HDR_BYTES)
            v.st = STATUS_SHORT;
        else if (hdr_type != ECHO_REQUEST_TYPE || hdr_code != ECHO_CODE)
            v.st = STATUS_BAD_TYPE;
        else if (sum_all != SUM_ALL_ONES)
            v.st = STATUS_BAD_SUM;
        else
        begin
            v.st    = STATUS_OK;
            v.ident = echo_id;
            v.seq   = echo_seq;
            v.plen  = 16'(rx_count - HDR_BYTES);
            v.rcsum = ~sum_tail;
        end
        pending_verdicts.push_back(v);
        status_hits[v.st]++;
        msgs_sent++;
        clear_msg_state();
    endfunction

    // receiver: random stalls, or a counted hold-off when one is asked for
    always @(posedge clk)
    begin
        if (hold_ask_id != hold_done_id)
        begin
            hold_done_id = hold_ask_id;
            hold_left    = hold_ask_len;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
    end

    // verdict checker: every output transaction against the oldest expectation
    always @(posedge clk)
    begin : verdict_check
        echo_verdict_t got;
        echo_verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.st    = status_t'(status);
            got.ident = identifier;
            got.seq   = sequence_res;
            got.plen  = payload_length;
            got.rcsum = reply_checksum;
            verdicts_checked++;
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected verdict: status %0d id %h seq %h len %0d csum %h",
                             got.st, got.ident, got.seq, got.plen, got.rcsum);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.st !== want.st || got.ident !== want.ident || got.seq !== want.seq
                    || got.plen !== want.plen || got.rcsum !== want.rcsum)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("verdict %0d expected: status %0d id %h seq %h len %0d csum %h",
                                 verdicts_checked, want.st, want.ident, want.seq, want.plen,
                                 want.rcsum);
                        $display("verdict %0d actual:   status %0d id %h seq %h len %0d csum %h",
                                 verdicts_checked, got.st, got.ident, got.seq, got.plen,
                                 got.rcsum);
                    end
                end
            end
        end
    end

    // offer one byte, with an optional idle gap first, and wait for the transaction
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!quiet_mode && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_echo_byte(b, fin);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // sender pause: drop in_valid and wait until no verdict is owed, then let the pipeline settle
    task automatic wait_all_verdicts();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // header with a zero checksum field
    function automatic void start_echo(input logic [7:0] typ, input logic [7:0] code,
                                       input logic [15:0] id, input logic [15:0] sq);
        pkt.delete();
        pkt.push_back(typ);
        pkt.push_back(code);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(id[15:8]);
        pkt.push_back(id[7:0]);
        pkt.push_back(sq[15:8]);
        pkt.push_back(sq[7:0]);
    endfunction

    // fill bytes 2 and 3 so the whole message folds to all ones
    function automatic void seal_checksum();
        logic [15:0] acc;
        int          i;
        acc    = 16'h0000;
        pkt[2] = 8'h00;
        pkt[3] = 8'h00;
        for (i = 0; i < pkt.size(); i += 2)
            acc = csum_add(acc, {pkt[i], (i + 1 < pkt.size()) ? pkt[i + 1] : 8'h00});
        pkt[2] = ~acc[15:8];
        pkt[3] = ~acc[7:0];
    endfunction

    // extremes, precedence and the all-zero sum
    task automatic test_directed();
        // lone byte, short wins over a wrong type
        pkt.delete();
        pkt.push_back(8'h00);
        send_packet();

        // header only, identifier all ones, sequence all zeros
        start_echo(ECHO_REQUEST_TYPE, ECHO_CODE, 16'hFFFF, 16'h0000);
        seal_checksum();
        send_packet();

        // odd length, all-ones payload byte padded low
        start_echo(ECHO_REQUEST_TYPE, ECHO_CODE, 16'h0000, 16'hFFFF);
        pkt.push_back(8'hFF);
        seal_checksum();
        send_packet();

        // all-zero message: sum folds to zero, type check comes first
        start_echo(8'h00, 8'h00, 16'h0000, 16'h0000);
        send_packet();
        wait_all_verdicts();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        int k;
        int i;
        int extra;
        quiet_mode   = 1'b1;
        hold_ask_len = 300;
        hold_ask_id++;
        for (k = 0; k < 10; k++)
        begin
            start_echo(ECHO_REQUEST_TYPE, ECHO_CODE, 16'($urandom), 16'($urandom));
            extra = $urandom_range(3);
            for (i = 0; i < extra; i++)
                pkt.push_back(8'($urandom));
            seal_checksum();
            send_packet();
        end
        quiet_mode = 1'b0;
        wait_all_verdicts();
    endtask

    // mostly well-formed requests, mixed with corrupted, wrong-type, short and raw noise
    task automatic test_random();
        int sent;
        int kind;
        int len;
        int i;
        sent = 0;
        while (sent < 930)
        begin
            quiet_mode = (sent >= 350 && sent < 650);
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                len = $urandom_range(24, 8);
                start_echo(ECHO_REQUEST_TYPE, ECHO_CODE, 16'($urandom), 16'($urandom));
                for (i = 8; i < len; i++)
                    pkt.push_back(8'($urandom));
                // wrong type or code, checksum still consistent
                if (kind >= 70)
                begin
                    if ($urandom_range(1))
                        pkt[0] = pkt[0] ^ 8'($urandom_range(255, 1));
                    else
                        pkt[1] = pkt[1] ^ 8'($urandom_range(255, 1));
                end
                seal_checksum();
                // single bit flip breaks the checksum
                if (kind >= 55 && kind < 70)
                begin
                    i = $urandom_range(len - 1);
                    pkt[i] = pkt[i] ^ (8'h01 << $urandom_range(7));
                end
            end
            else
            begin
                len = (kind < 90) ? $urandom_range(7, 1) : $urandom_range(40, 1);
                pkt.delete();
                for (i = 0; i < len; i++)
                    pkt.push_back((i == 0 && $urandom_range(1)) ? ECHO_REQUEST_TYPE
                                                                : 8'($urandom));
            end
            send_packet();
            sent += pkt.size();
        end
        quiet_mode = 1'b0;
        wait_all_verdicts();
    endtask

    // test sequence
    initial
    begin
        clear_msg_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random();
        repeat (8) @(posedge clk);

        $display("run covered %0d messages in %0d bytes, %0d verdicts checked",
                 msgs_sent, bytes_sent, verdicts_checked);
        $display("verdicts by status ok/short/type/sum: %0d/%0d/%0d/%0d, mismatches %0d",
                 status_hits[STATUS_OK], status_hits[STATUS_SHORT],
                 status_hits[STATUS_BAD_TYPE], status_hits[STATUS_BAD_SUM], mismatch_count);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("icmp_echo_request_checker: match");
        else
            $display("icmp_echo_request_checker: mismatch");
        $finish;
    end

endmodule
